// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition holds a fixed number of cycles after its trigger
`define AST_DELAY(lbl, clk, rstn, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
        else $error("delayed check failed");

`endif

// ===== rtl/thts_pkg.sv =====
// ---------------------------------------------------------------------------
// thts_pkg
// Types and constants of the terrain height triangle sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package thts_pkg;

    // Field widths
    localparam int POS_W  = 24;
    localparam int HGT_W  = 24;
    localparam int CELL_W = 9;
    localparam int GRID_W = 10;
    localparam int INV_W  = 24;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Cycles from the accepting edge to the edge that takes the result
    localparam int LATENCY = 8;

    // Height reported for a position off the grid (-100 m in Q.8)
    localparam logic signed [HGT_W-1:0] OUTSIDE_HEIGHT = -24'sd25600;

    // Register reset values
    localparam logic [GRID_W-1:0] GRID_COLS_RST = 10'd512;
    localparam logic [GRID_W-1:0] GRID_ROWS_RST = 10'd512;
    localparam logic [INV_W-1:0]  INV_CELL_RST  = 24'd335544;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_GRID_COLS = 2'd0,
        REG_GRID_ROWS = 2'd1,
        REG_INV_CELL  = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== rtl/terrain_height_triangle_sampler.sv =====
// A sample word accepted at one edge shows its result with o_strobe for one
// cycle, once it has passed the registers of stages 0 to 7.
// Throughput: one word per cycle; the four banked height stores each give one
// cell corner per cycle, and each pipeline stage holds one word.
// Reset (synchronous, active low) clears the valid bits, the strobe and the
// configuration registers; the height store keeps its contents and needs no clearing.
// ---------------------------------------------------------------------------
// terrain_height_triangle_sampler
// Heightmap store with a pipelined triangle interpolator: scale, split into
// cell and fraction, read four corners from four parity banks, interpolate.
// ---------------------------------------------------------------------------
`default_nettype none

module terrain_height_triangle_sampler #(
    parameter int MAX_SIDE = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_action,
    input  logic signed [thts_pkg::POS_W-1:0]    i_x_pos,
    input  logic signed [thts_pkg::POS_W-1:0]    i_z_pos,
    input  logic        [thts_pkg::CELL_W-1:0]   i_cell_col,
    input  logic        [thts_pkg::CELL_W-1:0]   i_cell_row,
    input  logic signed [thts_pkg::HGT_W-1:0]    i_height_in,
    // Result channel
    output logic                                 o_strobe,
    output logic signed [thts_pkg::HGT_W-1:0]    o_height_out,
    output logic                                 o_outside,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [thts_pkg::ADDR_W-1:0]   paddr,
    input  logic        [thts_pkg::DATA_W-1:0]   pwdata,
    output logic        [thts_pkg::DATA_W-1:0]   prdata,
    output logic                                 pready
);
    import thts_pkg::*;

    // Index widths: IW bits per full index, HW bits per half index per bank
    localparam int IW    = $clog2(MAX_SIDE);
    localparam int HW    = (IW > 1) ? IW - 1 : 1;
    localparam int DEPTH = 1 << (2 * HW);
    localparam int XW    = 16;
    localparam logic [XW-1:0] SIDE_W = XW'(MAX_SIDE);

    // ---------------- configuration registers ----------------
    logic [GRID_W-1:0] r_grid_cols;
    logic [GRID_W-1:0] r_grid_rows;
    logic [INV_W-1:0]  r_inv_cell;
    t_reg_idx          w_reg_idx;
    logic              w_cfg_wr;

    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign busy      = 1'b0;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_COLS_RST;
            r_grid_rows <= GRID_ROWS_RST;
            r_inv_cell  <= INV_CELL_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_GRID_COLS: r_grid_cols <= pwdata[GRID_W-1:0];
                REG_GRID_ROWS: r_grid_rows <= pwdata[GRID_W-1:0];
                REG_INV_CELL:  r_inv_cell  <= pwdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_reg_idx)
            REG_GRID_COLS: prdata = {{(DATA_W-GRID_W){1'b0}}, r_grid_cols};
            REG_GRID_ROWS: prdata = {{(DATA_W-GRID_W){1'b0}}, r_grid_rows};
            REG_INV_CELL:  prdata = {{(DATA_W-INV_W){1'b0}}, r_inv_cell};
            default:       prdata = '0;
        endcase
    end

    // ---------------- stage 0: capture the word ----------------
    logic                     r_v0, r_act0;
    logic signed [POS_W-1:0]  r_x0, r_z0;
    logic [CELL_W-1:0]        r_col0, r_row0;
    logic signed [HGT_W-1:0]  r_h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act0 <= i_action;
        r_x0   <= i_x_pos;
        r_z0   <= i_z_pos;
        r_col0 <= i_cell_col;
        r_row0 <= i_cell_row;
        r_h0   <= i_height_in;
    end

    // ---------------- stage 1: scale by reciprocal cell size ----------------
    logic                     r_v1, r_act1;
    logic signed [48:0]       r_px1, r_pz1;
    logic [CELL_W-1:0]        r_col1, r_row1;
    logic signed [HGT_W-1:0]  r_h1;
    logic signed [48:0]       n_px1, n_pz1;

    assign n_px1 = r_x0 * $signed({1'b0, r_inv_cell});
    assign n_pz1 = r_z0 * $signed({1'b0, r_inv_cell});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act1 <= r_act0;
        r_px1  <= n_px1;
        r_pz1  <= n_pz1;
        r_col1 <= r_col0;
        r_row1 <= r_row0;
        r_h1   <= r_h0;
    end

    // ---------------- stage 2: split, range check, bank addresses ----------------
    logic [XW-1:0]       w_xi, w_zi, w_cols_eff, w_rows_eff, w_gcols, w_grows;
    logic [XW-1:0]       w_wcol, w_wrow;
    logic [15:0]         w_fx, w_fz;
    logic [16:0]         w_fsum;
    logic                n_out2, n_we2;
    logic [2*HW-1:0]     n_ra2 [4];
    logic [XW-1:0]       w_cx, w_cz;

    assign w_xi   = r_px1[47:32];
    assign w_zi   = r_pz1[47:32];
    assign w_fx   = r_px1[31:16];
    assign w_fz   = r_pz1[31:16];
    assign w_fsum = {1'b0, w_fx} + {1'b0, w_fz};

    // Clamp oversized grids to the store side
    assign w_gcols    = {{(XW-GRID_W){1'b0}}, r_grid_cols};
    assign w_grows    = {{(XW-GRID_W){1'b0}}, r_grid_rows};
    assign w_cols_eff = (w_gcols > SIDE_W) ? SIDE_W : w_gcols;
    assign w_rows_eff = (w_grows > SIDE_W) ? SIDE_W : w_grows;

    assign n_out2 = r_px1[48] || r_pz1[48] ||
                    ((w_xi + XW'(1)) >= w_cols_eff) || ((w_zi + XW'(1)) >= w_rows_eff);

    // Each bank holds one corner: step to the odd/even neighbor it owns
    always_comb begin
        w_cx = '0;
        w_cz = '0;
        for (int b = 0; b < 4; b++) begin
            w_cx = w_xi + XW'(w_xi[0] != b[0]);
            w_cz = w_zi + XW'(w_zi[0] != b[1]);
            n_ra2[b] = {w_cz[HW:1], w_cx[HW:1]};
        end
    end

    // Drop writes beyond the store side
    assign w_wcol = {{(XW-CELL_W){1'b0}}, r_col1};
    assign w_wrow = {{(XW-CELL_W){1'b0}}, r_row1};
    assign n_we2  = r_v1 && !r_act1 && (w_wcol < SIDE_W) && (w_wrow < SIDE_W);

    logic                    r_sv2, r_we2, r_out2, r_far2, r_xp2, r_zp2;
    logic [15:0]             r_fx2, r_fz2;
    logic [2*HW-1:0]         r_ra2 [4];
    logic [1:0]              r_wb2;
    logic [2*HW-1:0]         r_wa2;
    logic signed [HGT_W-1:0] r_h2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv2 <= 1'b0;
            r_we2 <= 1'b0;
        end else begin
            r_sv2 <= r_v1 && r_act1;
            r_we2 <= n_we2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out2 <= n_out2;
        r_far2 <= (w_fsum > 17'd65536);
        r_xp2  <= w_xi[0];
        r_zp2  <= w_zi[0];
        r_fx2  <= w_fx;
        r_fz2  <= w_fz;
        r_ra2  <= n_ra2;
        r_wb2  <= {w_wrow[0], w_wcol[0]};
        r_wa2  <= {w_wrow[HW:1], w_wcol[HW:1]};
        r_h2   <= r_h1;
    end

    // ---------------- stage 3: banked height store ----------------
    logic signed [HGT_W-1:0] r_rd3 [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic signed [HGT_W-1:0] r_mem [DEPTH];

        // Write one height, read one corner
        always_ff @(posedge i_clk) begin
            if (r_we2 && (r_wb2 == 2'(b))) begin
                r_mem[r_wa2] <= r_h2;
            end
            r_rd3[b] <= r_mem[r_ra2[b]];
        end
    end

    logic        r_sv3, r_out3, r_far3, r_xp3, r_zp3;
    logic [15:0] r_fx3, r_fz3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv3 <= 1'b0;
        end else begin
            r_sv3 <= r_sv2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out3 <= r_out2;
        r_far3 <= r_far2;
        r_xp3  <= r_xp2;
        r_zp3  <= r_zp2;
        r_fx3  <= r_fx2;
        r_fz3  <= r_fz2;
    end

    // ---------------- stage 4: corners and triangle terms ----------------
    logic signed [25:0] w_e00, w_e01, w_e10, w_e11;
    logic signed [25:0] n_base4, w_dx26, w_dz26;

    assign w_e00 = 26'(r_rd3[{r_zp3,  r_xp3}]);
    assign w_e01 = 26'(r_rd3[{r_zp3, ~r_xp3}]);
    assign w_e10 = 26'(r_rd3[{~r_zp3, r_xp3}]);
    assign w_e11 = 26'(r_rd3[{~r_zp3, ~r_xp3}]);

    // Near triangle from the origin corner, far triangle from the opposite one
    always_comb begin
        if (r_far3) begin
            n_base4 = w_e10 + w_e01 - w_e11;
            w_dx26  = w_e11 - w_e10;
            w_dz26  = w_e11 - w_e01;
        end else begin
            n_base4 = w_e00;
            w_dx26  = w_e01 - w_e00;
            w_dz26  = w_e10 - w_e00;
        end
    end

    logic               r_sv4, r_out4;
    logic signed [25:0] r_base4;
    logic signed [24:0] r_dx4, r_dz4;
    logic [15:0]        r_fx4, r_fz4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv4 <= 1'b0;
        end else begin
            r_sv4 <= r_sv3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out4  <= r_out3;
        r_base4 <= n_base4;
        r_dx4   <= w_dx26[24:0];
        r_dz4   <= w_dz26[24:0];
        r_fx4   <= r_fx3;
        r_fz4   <= r_fz3;
    end

    // ---------------- stage 5: weight the slopes ----------------
    logic               r_sv5, r_out5;
    logic signed [25:0] r_base5;
    logic signed [41:0] r_px5, r_pz5;
    logic signed [41:0] n_px5, n_pz5;

    assign n_px5 = r_dx4 * $signed({1'b0, r_fx4});
    assign n_pz5 = r_dz4 * $signed({1'b0, r_fz4});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv5 <= 1'b0;
        end else begin
            r_sv5 <= r_sv4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out5  <= r_out4;
        r_base5 <= r_base4;
        r_px5   <= n_px5;
        r_pz5   <= n_pz5;
    end

    // ---------------- stage 6: sum at Q.8 * 2^16 ----------------
    logic               r_sv6, r_out6;
    logic signed [43:0] r_acc6;
    logic signed [43:0] n_acc6;

    assign n_acc6 = {{2{r_base5[25]}}, r_base5, 16'd0} +
                    {{2{r_px5[41]}}, r_px5} + {{2{r_pz5[41]}}, r_pz5};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv6 <= 1'b0;
        end else begin
            r_sv6 <= r_sv5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out6 <= r_out5;
        r_acc6 <= n_acc6;
    end

    // ---------------- stage 7: round, saturate, present ----------------
    logic signed [43:0]      w_rsum;
    logic signed [27:0]      w_rnd;
    logic signed [HGT_W-1:0] w_sat;

    assign w_rsum = r_acc6 + 44'sd32768;
    assign w_rnd  = w_rsum[43:16];

    // Round half up, then clamp to 24 bits
    always_comb begin
        if (w_rnd > 28'sd8388607) begin
            w_sat = 24'sh7FFFFF;
        end else if (w_rnd < -28'sd8388608) begin
            w_sat = -24'sh800000;
        end else begin
            w_sat = w_rnd[HGT_W-1:0];
        end
    end

    logic                    r_strobe, r_outside;
    logic signed [HGT_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_sv6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_outside <= r_out6;
        r_height  <= r_out6 ? OUTSIDE_HEIGHT : w_sat;
    end

    assign o_strobe     = r_strobe;
    assign o_outside    = r_outside;
    assign o_height_out = r_height;

endmodule

`default_nettype wire

// ===== rtl/thts_checker.sv =====
// ---------------------------------------------------------------------------
// thts_checker
// Port-level checks of the terrain height triangle sampler, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module thts_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_action,
    input logic                              o_strobe,
    input logic signed [thts_pkg::HGT_W-1:0] o_height_out,
    input logic                              o_outside
);
    import thts_pkg::*;

    logic w_take_sample, w_take_write;

    assign w_take_sample = start && !busy && i_action;
    assign w_take_write  = start && !busy && !i_action;

    // Never refuse a word
    `AST_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)

    // Every sample word yields one result after the pipeline delay
    `AST_DELAY(a_sample_result, i_clk, i_rst_n, w_take_sample, LATENCY, o_strobe)

    // A write word leaves its result slot empty
    `AST_DELAY(a_write_silent, i_clk, i_rst_n, w_take_write, LATENCY, !o_strobe)

    // Off-grid results carry the fixed height
    `AST_IMPL(a_outside_height, i_clk, i_rst_n, o_strobe && o_outside,
              o_height_out == OUTSIDE_HEIGHT)

endmodule

bind terrain_height_triangle_sampler thts_checker u_thts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .o_strobe     (o_strobe),
    .o_height_out (o_height_out),
    .o_outside    (o_outside)
);

`default_nettype wire

// ===== test/terrain_height_triangle_sampler_tb.sv =====
// ---------------------------------------------------------------------------
// terrain_height_triangle_sampler_tb
// Drives cell-height writes and position samples into the heightmap sampler,
// keeps its own copy of the grid and registers, predicts the height and
// outside flag of every sample and compares each strobed word in order.
// ---------------------------------------------------------------------------
`default_nettype none

module terrain_height_triangle_sampler_tb;

    import thts_pkg::*;

    localparam int MAX_SIDE  = 512;
    localparam int CLK_LIMIT = 200000;
    localparam int SETTLE    = LATENCY + 4;

    localparam logic signed [HGT_W-1:0] HGT_MAX = 24'sh7FFFFF;
    localparam logic signed [HGT_W-1:0] HGT_MIN = 24'sh800000;
    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef struct {
        t_action                  action;
        logic signed [POS_W-1:0]  x_pos;
        logic signed [POS_W-1:0]  z_pos;
        logic        [CELL_W-1:0] cell_col;
        logic        [CELL_W-1:0] cell_row;
        logic signed [HGT_W-1:0]  height_in;
    } t_terrain_word;

    typedef struct {
        logic signed [HGT_W-1:0] height;
        logic                    outside;
    } t_height_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              start   = 1'b0;
    logic              busy;
    logic              o_strobe;
    logic signed [HGT_W-1:0] o_height_out;
    logic              o_outside;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_terrain_word cur_word = '{ACT_WRITE, '0, '0, '0, '0, '0};

    // Words waiting to be sent and heights waiting to come back
    t_terrain_word  word_q[$];
    t_height_result height_q[$];

    // Predictor copy of the grid, the registers and the load map
    logic signed [HGT_W-1:0] height_mem [0:MAX_SIDE*MAX_SIDE-1];
    bit                      cell_loaded[0:MAX_SIDE*MAX_SIDE-1];
    logic [GRID_W-1:0]       cfg_cols = GRID_COLS_RST;
    logic [GRID_W-1:0]       cfg_rows = GRID_ROWS_RST;
    logic [INV_W-1:0]        cfg_inv  = INV_CELL_RST;

    bit          word_taken = 1'b0;
    bit          gaps_on    = 1'b1;
    int          gap_left   = 0;
    int          items_made = 0;
    int          err_count  = 0;
    int unsigned cycle_cnt  = 0;

    logic                     i_action;
    logic signed [POS_W-1:0]  i_x_pos;
    logic signed [POS_W-1:0]  i_z_pos;
    logic        [CELL_W-1:0] i_cell_col;
    logic        [CELL_W-1:0] i_cell_row;
    logic signed [HGT_W-1:0]  i_height_in;

    assign i_action    = cur_word.action;
    assign i_x_pos     = cur_word.x_pos;
    assign i_z_pos     = cur_word.z_pos;
    assign i_cell_col  = cur_word.cell_col;
    assign i_cell_row  = cur_word.cell_row;
    assign i_height_in = cur_word.height_in;

    terrain_height_triangle_sampler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_x_pos      (i_x_pos),
        .i_z_pos      (i_z_pos),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .i_height_in  (i_height_in),
        .o_strobe     (o_strobe),
        .o_height_out (o_height_out),
        .o_outside    (o_outside),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Height prediction
    // ---------------------------------------------------------------------

    function automatic int mem_index(input int col, input int row);
        return row * MAX_SIDE + col;
    endfunction

    function automatic longint side_limit(input logic [GRID_W-1:0] n);
        return (n > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(n);
    endfunction

    // Scale one coordinate; the cell is the integer part, the fraction Q0.16
    function automatic bit split_axis(input logic signed [POS_W-1:0] pos,
                                      output longint cell_idx, output longint frac);
        longint prod;
        prod = longint'(pos) * longint'(cfg_inv);
        cell_idx = prod >>> 32;
        frac = (prod >>> 16) & 64'hFFFF;
        return prod >= 0;
    endfunction

    // Return 1 when the position falls in a cell whose four corners lie on the grid
    function automatic bit locate_cell(input logic signed [POS_W-1:0] x,
                                       input logic signed [POS_W-1:0] z,
                                       output longint xi, output longint zi,
                                       output longint fx, output longint fz);
        bit ok_x;
        bit ok_z;
        ok_x = split_axis(x, xi, fx);
        ok_z = split_axis(z, zi, fz);
        return ok_x && ok_z && (xi + 1 < side_limit(cfg_cols))
            && (zi + 1 < side_limit(cfg_rows));
    endfunction

    function automatic t_height_result sample_terrain(input logic signed [POS_W-1:0] x,
                                                      input logic signed [POS_W-1:0] z);
        longint xi, zi, fx, fz;
        longint y00, y01, y10, y11, acc, r;
        t_height_result res;
        if (!locate_cell(x, z, xi, zi, fx, fz)) begin
            res.height  = OUTSIDE_HEIGHT;
            res.outside = 1'b1;
            return res;
        end
        y00 = height_mem[mem_index(int'(xi),     int'(zi))];
        y01 = height_mem[mem_index(int'(xi + 1), int'(zi))];
        y10 = height_mem[mem_index(int'(xi),     int'(zi + 1))];
        y11 = height_mem[mem_index(int'(xi + 1), int'(zi + 1))];
        // Pick the near or far triangle of the cell
        if (fx + fz <= 65536) begin
            acc = y00 * 65536 + (y10 - y00) * fz + (y01 - y00) * fx;
        end else begin
            acc = (y10 + y01 - y11) * 65536 - (y10 - y11) * fx - (y01 - y11) * fz;
        end
        // Round to nearest with ties up, then clamp to the output width
        r = (acc + 32768) >>> 16;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        res.height  = r[HGT_W-1:0];
        res.outside = 1'b0;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------------

    function automatic logic signed [HGT_W-1:0] rand_height();
        logic signed [HGT_W-1:0] h;
        if ($urandom_range(0, 1) == 0) h = HGT_W'($urandom());
        else h = HGT_W'(int'($urandom_range(0, 40000)) - 20000);
        return h;
    endfunction

    function automatic logic [INV_W-1:0] random_inv();
        if ($urandom_range(0, 3) == 0) return INV_W'($urandom_range(1, 65535));
        return INV_W'($urandom_range(65536, 24'hFFFFFF));
    endfunction

    // Position with a given cell index and fraction when the scale is 1.0
    function automatic logic signed [POS_W-1:0] grid_pos(input int cell_idx, input int frac);
        return POS_W'(cell_idx * 65536 + frac);
    endfunction

    // Aim a coordinate at a random cell of the grid, edge cells included
    function automatic logic signed [POS_W-1:0] aim_pos(input logic [GRID_W-1:0] side_cfg);
        longint side, cell_idx, target, p;
        side = side_limit(side_cfg);
        if (side < 2 || cfg_inv == 0) return POS_W'($urandom());
        cell_idx = $urandom_range(0, int'(side - 1));
        target   = (cell_idx << 32) + longint'($urandom());
        p        = target / longint'(cfg_inv);
        if (p > 8388607) return POS_W'($urandom());
        return p[POS_W-1:0];
    endfunction

    // Append one word to the send queue
    task automatic queue_word(input t_terrain_word w);
        word_q = {word_q, w};
    endtask

    task automatic load_cell(input int col, input int row, input logic signed [HGT_W-1:0] h);
        queue_word('{ACT_WRITE, POS_W'($urandom()), POS_W'($urandom()),
                     CELL_W'(col), CELL_W'(row), h});
        cell_loaded[mem_index(col, row)] = 1'b1;
        items_made++;
    endtask

    task automatic load_corner(input int col, input int row);
        if (!cell_loaded[mem_index(col, row)]) load_cell(col, row, rand_height());
    endtask

    // Queue a sample, loading first any corner it reads that was never written
    task automatic queue_sample(input logic signed [POS_W-1:0] x,
                                input logic signed [POS_W-1:0] z);
        longint xi, zi, fx, fz;
        if (locate_cell(x, z, xi, zi, fx, fz)) begin
            load_corner(int'(xi),     int'(zi));
            load_corner(int'(xi + 1), int'(zi));
            load_corner(int'(xi),     int'(zi + 1));
            load_corner(int'(xi + 1), int'(zi + 1));
        end
        queue_word('{ACT_SAMPLE, x, z, CELL_W'($urandom()), CELL_W'($urandom()),
                     HGT_W'($urandom())});
        items_made++;
    endtask

    // Mostly aimed samples, some full-range positions and stray writes
    task automatic run_random(input int n);
        int goal;
        int pick;
        goal = items_made + n;
        while (items_made < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                load_cell($urandom_range(0, MAX_SIDE - 1), $urandom_range(0, MAX_SIDE - 1),
                          rand_height());
            else if (pick < 22)
                queue_sample(POS_W'($urandom()), POS_W'($urandom()));
            else
                queue_sample(aim_pos(cfg_cols), aim_pos(cfg_rows));
        end
    endtask

    // ---------------------------------------------------------------------
    // Checking helpers and register access
    // ---------------------------------------------------------------------

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Hold until every word is sent and answered, then let the pipe empty
    task automatic wait_idle();
        while (word_q.size() != 0 || start || height_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [DATA_W-1:0] field);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] readback;
        mask = (idx == REG_INV_CELL) ? DATA_W'((1 << INV_W) - 1)
                                     : DATA_W'((1 << GRID_W) - 1);
        // Write with junk in the unused upper bits
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= (DATA_W'($urandom()) & ~mask) | (field & mask);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_GRID_COLS: cfg_cols = field[GRID_W-1:0];
            REG_GRID_ROWS: cfg_rows = field[GRID_W-1:0];
            REG_INV_CELL:  cfg_inv  = field[INV_W-1:0];
            default: ;
        endcase
        // Read it back
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((readback & mask) !== (field & mask))
            note_error($sformatf("register %s reads %0h, expected %0h",
                                 idx.name(), readback & mask, field & mask));
    endtask

    task automatic set_grid(input logic [GRID_W-1:0] cols, input logic [GRID_W-1:0] rows,
                            input logic [INV_W-1:0] inv);
        wait_idle();
        program_reg(REG_GRID_COLS, DATA_W'(cols));
        program_reg(REG_GRID_ROWS, DATA_W'(rows));
        program_reg(REG_INV_CELL,  DATA_W'(inv));
    endtask

    // ---------------------------------------------------------------------
    // Driver: present the next word at the falling edge
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            word_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (word_q.size() > 0) begin
                cur_word = word_q.pop_front();
                start <= 1'b1;
                if (gaps_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 16);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: take accepted words into the model, check strobed results
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_height_result want;
        cycle_cnt++;
        if (cycle_cnt >= CLK_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (start && !busy) begin
                word_taken = 1'b1;
                if (cur_word.action == ACT_WRITE)
                    height_mem[mem_index(cur_word.cell_col, cur_word.cell_row)] =
                        cur_word.height_in;
                else
                    height_q = {height_q, sample_terrain(cur_word.x_pos, cur_word.z_pos)};
            end
            if (o_strobe) begin
                if (height_q.size() == 0) begin
                    note_error($sformatf("unexpected word: height %0d outside %0b",
                                         o_height_out, o_outside));
                end else begin
                    want = height_q.pop_front();
                    if (o_height_out !== want.height || o_outside !== want.outside)
                        note_error($sformatf("height %0d outside %0b, expected %0d / %0b",
                                             o_height_out, o_outside,
                                             want.height, want.outside));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence of phases
    // ---------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: grid edges, negative and extreme positions
        queue_sample(POS_MAX, '0);
        queue_sample(POS_MIN, POS_MIN);
        queue_sample('0, POS_MAX);
        load_cell(MAX_SIDE - 1, MAX_SIDE - 1, HGT_MAX);
        load_cell(0, 0, HGT_MIN);
        queue_sample(24'sd6534400, 24'sd6534400);
        queue_sample(24'sd6540900, 24'sd100);
        queue_sample('0, '0);

        // Unit scale: fractions set directly, triangle split and saturation
        set_grid(10'd512, 10'd512, 24'd65536);
        load_cell(2, 2, HGT_MAX);
        load_cell(3, 2, HGT_MIN);
        load_cell(2, 3, HGT_MIN);
        load_cell(3, 3, HGT_MAX);
        queue_sample(grid_pos(2, 0), grid_pos(2, 0));
        queue_sample(grid_pos(2, 16'hFFFF), grid_pos(2, 16'hFFFF));
        queue_sample(grid_pos(2, 16'h8000), grid_pos(2, 16'h8000));
        queue_sample(grid_pos(2, 16'h8001), grid_pos(2, 16'h8000));
        queue_sample(grid_pos(2, 16'hFFFF), grid_pos(2, 1));
        load_cell(5, 5, HGT_MIN);
        load_cell(6, 5, HGT_MAX);
        load_cell(5, 6, HGT_MAX);
        load_cell(6, 6, HGT_MIN);
        queue_sample(grid_pos(5, 16'hFFFF), grid_pos(5, 16'hFFFF));
        queue_sample(grid_pos(5, 16'h4000), grid_pos(5, 16'hC001));
        queue_sample(-24'sd1, grid_pos(2, 0));
        queue_sample(grid_pos(2, 0), -24'sd256);

        set_grid(GRID_COLS_RST, GRID_ROWS_RST, INV_CELL_RST);
        run_random(200);

        // Smallest grid at the largest scale
        set_grid(10'd2, 10'd2, 24'hFFFFFF);
        run_random(60);

        // Oversized column count acts as the full side
        set_grid(10'd1023, 10'd37, random_inv());
        run_random(150);

        // Grid too small: every sample is outside
        set_grid(10'd1, 10'd0, random_inv());
        run_random(40);

        // Zero scale: every sample lands on cell zero
        set_grid(GRID_W'($urandom_range(2, 512)), GRID_W'($urandom_range(2, 512)), '0);
        run_random(40);

        // Random grid; hold the sender once until all heights are back
        set_grid(GRID_W'($urandom_range(2, 512)), GRID_W'($urandom_range(2, 512)),
                 random_inv());
        run_random(150);
        wait_idle();
        run_random(150);

        // Back-to-back words to the end
        wait_idle();
        gaps_on = 1'b0;
        set_grid(GRID_COLS_RST, GRID_ROWS_RST, INV_CELL_RST);
        run_random(100);

        wait_idle();
        if (height_q.size() != 0)
            note_error($sformatf("%0d heights never arrived", height_q.size()));
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
